### hw/rtl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, codes and pipeline token types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DW = 16;
  localparam int FW = 8;
  localparam int PW = 2 * DW;
  localparam int SW = 2 * DW + 1;
  localparam int RW = 2 * DW;
  localparam int QW = 2 * DW + FW;
  localparam int NCELLS = QW;
  localparam int LATENCY = NCELLS + 3;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic          neg;
    logic [QW-1:0] q;
    logic [RW-1:0] rem;
    logic [QW-1:0] dvd;
  } lane_t;

  typedef struct packed {
    logic          valid;
    logic [1:0]    op;
    logic          zdiv;
    logic [RW-1:0] den;
    lane_t         re;
    lane_t         im;
  } tok_t;

endpackage

### hw/rtl/complex_arithmetic_unit_core.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined complex add, subtract, multiply and divide on signed Q8.8 values.
// ----------------------------------------------------------------------------
// usage:
//   a request is taken on any rising edge with start high and busy low; busy
//   stays low, so a new request may be issued every cycle
//   command selects add, subtract, multiply or divide of a by b
//   the result appears on res_re, res_im and status for exactly one cycle,
//   marked by done, after the request has passed through the registers of
//   2 front stages, one division cell per quotient bit (40 cells), then one
//   output stage
//   throughput is one request per cycle; every request passes the whole
//   cell chain, so latency is the same for all commands
//   status: ok, saturated, or divide by zero (results then zero)
//   reset clears all valid flags in flight; requests in flight are dropped
//   the receiver cannot stall: results must be taken when done is high
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    command,
  input  logic signed [cau_pkg::DW-1:0] a_re,
  input  logic signed [cau_pkg::DW-1:0] a_im,
  input  logic signed [cau_pkg::DW-1:0] b_re,
  input  logic signed [cau_pkg::DW-1:0] b_im,
  output logic                          done,
  output logic signed [cau_pkg::DW-1:0] res_re,
  output logic signed [cau_pkg::DW-1:0] res_im,
  output logic [1:0]                    status
);

  cau_pkg::tok_t chain [cau_pkg::NCELLS+1];

  assign busy = 1'b0;

  cau_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (start && !busy),
    .command (command),
    .a_re    (a_re),
    .a_im    (a_im),
    .b_re    (b_re),
    .b_im    (b_im),
    .tok     (chain[0])
  );

  for (genvar i = 0; i < cau_pkg::NCELLS; i++) begin : g_cell
    cau_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  cau_back u_back (
    .clk    (clk),
    .rst    (rst),
    .tok    (chain[cau_pkg::NCELLS]),
    .done   (done),
    .res_re (res_re),
    .res_im (res_im),
    .status (status)
  );

`ifndef SYNTHESIS
  a_done_follows_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, cau_pkg::LATENCY))
    else $error("result without matching request");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == cau_pkg::ST_OK || status == cau_pkg::ST_SAT ||
              status == cau_pkg::ST_DZ))
    else $error("bad status code");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == cau_pkg::ST_DZ) |-> (res_re == '0 && res_im == '0))
    else $error("divide by zero result not zero");

  a_dz_only_div: assert property (@(posedge clk) disable iff (rst)
    (done && status == cau_pkg::ST_DZ) |->
      $past(command, cau_pkg::LATENCY) == cau_pkg::OP_DIV)
    else $error("divide by zero status on other command");
`endif

endmodule

### hw/rtl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Products, sums and sign-magnitude split of the operands into a pipe token.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [1:0]                  command,
  input  logic signed [cau_pkg::DW-1:0] a_re,
  input  logic signed [cau_pkg::DW-1:0] a_im,
  input  logic signed [cau_pkg::DW-1:0] b_re,
  input  logic signed [cau_pkg::DW-1:0] b_im,
  output cau_pkg::tok_t               tok
);

  logic                          s1_valid;
  logic [1:0]                    s1_op;
  logic signed [cau_pkg::DW-1:0] s1_a, s1_b, s1_c, s1_d;
  logic signed [cau_pkg::PW-1:0] s1_ac, s1_bd, s1_ad, s1_bc, s1_cc, s1_dd;

  logic signed [cau_pkg::DW:0]   sum_re, sum_im;
  logic signed [cau_pkg::SW-1:0] val_re, val_im;
  logic [cau_pkg::RW-1:0]        den;
  cau_pkg::tok_t                 tok_next;

  always_ff @(posedge clk) begin
    s1_op <= command;
    s1_a  <= a_re;
    s1_b  <= a_im;
    s1_c  <= b_re;
    s1_d  <= b_im;
    s1_ac <= a_re * b_re;
    s1_bd <= a_im * b_im;
    s1_ad <= a_re * b_im;
    s1_bc <= a_im * b_re;
    s1_cc <= b_re * b_re;
    s1_dd <= b_im * b_im;
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  function automatic cau_pkg::lane_t make_lane(logic signed [cau_pkg::SW-1:0] v,
                                               logic is_div);
    cau_pkg::lane_t        l;
    logic [cau_pkg::RW-1:0] mag;
    l.neg = v[cau_pkg::SW-1];
    mag   = l.neg ? cau_pkg::RW'(-v) : cau_pkg::RW'(v);
    l.rem = '0;
    if (is_div) begin
      l.q   = '0;
      l.dvd = cau_pkg::QW'({mag, {cau_pkg::FW{1'b0}}});
    end else begin
      l.q   = cau_pkg::QW'(mag);
      l.dvd = '0;
    end
    return l;
  endfunction

  always_comb begin
    if (s1_op == cau_pkg::OP_ADD) begin
      sum_re = (cau_pkg::DW+1)'(s1_a) + (cau_pkg::DW+1)'(s1_c);
      sum_im = (cau_pkg::DW+1)'(s1_b) + (cau_pkg::DW+1)'(s1_d);
    end else begin
      sum_re = (cau_pkg::DW+1)'(s1_a) - (cau_pkg::DW+1)'(s1_c);
      sum_im = (cau_pkg::DW+1)'(s1_b) - (cau_pkg::DW+1)'(s1_d);
    end
    den = cau_pkg::RW'(s1_cc) + cau_pkg::RW'(s1_dd);
    unique case (s1_op)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
        val_re = cau_pkg::SW'(sum_re);
        val_im = cau_pkg::SW'(sum_im);
      end
      cau_pkg::OP_MUL: begin
        val_re = cau_pkg::SW'(s1_ac) - cau_pkg::SW'(s1_bd);
        val_im = cau_pkg::SW'(s1_ad) + cau_pkg::SW'(s1_bc);
      end
      default: begin
        val_re = cau_pkg::SW'(s1_ac) + cau_pkg::SW'(s1_bd);
        val_im = cau_pkg::SW'(s1_bc) - cau_pkg::SW'(s1_ad);
      end
    endcase
    tok_next.valid = s1_valid;
    tok_next.op    = s1_op;
    tok_next.den   = den;
    tok_next.zdiv  = (den == '0);
    tok_next.re    = make_lane(val_re, s1_op == cau_pkg::OP_DIV);
    tok_next.im    = make_lane(val_im, s1_op == cau_pkg::OP_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

endmodule

### hw/rtl/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell
// One restoring division step per lane on divide tokens; passes every token to the next cell.
// ----------------------------------------------------------------------------
module cau_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  cau_pkg::tok_t tok_in,
  output cau_pkg::tok_t tok_out
);

  cau_pkg::tok_t tok_next;

  function automatic cau_pkg::lane_t step(cau_pkg::lane_t l, logic [cau_pkg::RW-1:0] den);
    cau_pkg::lane_t       o;
    logic [cau_pkg::RW:0] r2;
    logic                 qb;
    o  = l;
    r2 = {l.rem, l.dvd[cau_pkg::QW-1]};
    qb = (r2 >= {1'b0, den});
    if (qb) begin
      o.rem = cau_pkg::RW'(r2 - {1'b0, den});
    end else begin
      o.rem = r2[cau_pkg::RW-1:0];
    end
    o.dvd = {l.dvd[cau_pkg::QW-2:0], 1'b0};
    o.q   = {l.q[cau_pkg::QW-2:0], qb};
    return o;
  endfunction

  always_comb begin
    tok_next = tok_in;
    if (tok_in.op == cau_pkg::OP_DIV) begin
      tok_next.re = step(tok_in.re, tok_in.den);
      tok_next.im = step(tok_in.im, tok_in.den);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

### hw/rtl/cau_back.sv
// ----------------------------------------------------------------------------
// cau_back
// Rounding, saturation and status of the finished token; output register.
// ----------------------------------------------------------------------------
module cau_back (
  input  logic                          clk,
  input  logic                          rst,
  input  cau_pkg::tok_t                 tok,
  output logic                          done,
  output logic signed [cau_pkg::DW-1:0] res_re,
  output logic signed [cau_pkg::DW-1:0] res_im,
  output logic [1:0]                    status
);

  localparam logic [cau_pkg::QW:0] HALF =
    (cau_pkg::FW > 0) ? (cau_pkg::QW+1)'(1) << (cau_pkg::FW - 1) : '0;
  localparam logic [cau_pkg::QW:0] LIM = (cau_pkg::QW+1)'(1) << (cau_pkg::DW - 1);

  logic [cau_pkg::QW:0]   mag_re, mag_im;
  logic [cau_pkg::DW-1:0] fin_re, fin_im;
  logic                   sat_re, sat_im;

  function automatic logic [cau_pkg::QW:0] lane_mag(cau_pkg::lane_t l, logic [1:0] op,
                                                   logic [cau_pkg::RW-1:0] den);
    logic [cau_pkg::QW:0] m;
    logic                 rnd;
    rnd = ({l.rem, 1'b0} >= {1'b0, den});
    unique case (op)
      cau_pkg::OP_DIV: m = (cau_pkg::QW+1)'(l.q) + (cau_pkg::QW+1)'(rnd);
      cau_pkg::OP_MUL: m = ((cau_pkg::QW+1)'(l.q) + HALF) >> cau_pkg::FW;
      default:         m = (cau_pkg::QW+1)'(l.q);
    endcase
    return m;
  endfunction

  always_comb begin
    mag_re = lane_mag(tok.re, tok.op, tok.den);
    mag_im = lane_mag(tok.im, tok.op, tok.den);
    if (tok.re.neg) begin
      sat_re = mag_re > LIM;
      fin_re = sat_re ? cau_pkg::DW'(-LIM) : cau_pkg::DW'(-mag_re);
    end else begin
      sat_re = mag_re > LIM - 1'b1;
      fin_re = sat_re ? cau_pkg::DW'(LIM - 1'b1) : cau_pkg::DW'(mag_re);
    end
    if (tok.im.neg) begin
      sat_im = mag_im > LIM;
      fin_im = sat_im ? cau_pkg::DW'(-LIM) : cau_pkg::DW'(-mag_im);
    end else begin
      sat_im = mag_im > LIM - 1'b1;
      fin_im = sat_im ? cau_pkg::DW'(LIM - 1'b1) : cau_pkg::DW'(mag_im);
    end
  end

  always_ff @(posedge clk) begin
    if (tok.op == cau_pkg::OP_DIV && tok.zdiv) begin
      res_re <= '0;
      res_im <= '0;
      status <= cau_pkg::ST_DZ;
    end else begin
      res_re <= fin_re;
      res_im <= fin_im;
      status <= (sat_re || sat_im) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tok.valid;
    end
  end

endmodule
